// File: hdl/hba_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
// No dependencies; imported by every module of the block.
package hba_pkg;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = 4'd1;

   localparam int CFG_W       = 17;
   localparam int SIZE_W      = 16;
   localparam int POS_W       = 32;
   localparam int START_CHUNK = 4096;

   localparam logic [CFG_W-1:0] CHUNK_RESET = 17'd4096;
   localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd65536;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] addr;
   } hba_cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SIZE_W-1:0] addr;
   } hba_res_type;

endpackage

// File: hdl/boundary_tag_heap_allocator_core.sv
// Top level of the boundary-tag heap allocator: stream ports, control
// registers and the result register. Depends on hba_pkg and hba_seq.
//
//   channel  | ports                            | direction | carries
//   req      | req_tvalid/tready/tdata/tuser    | in        | allocate or release
//   rsp      | rsp_tvalid/tready/tdata          | out       | address and status
//   csr      | csr_valid/ready/index/data       | in        | chunk, heap limit
//
// Every heap access is a set-up step, then the memory port, plus a wrap
// step when a corrupt offset falls outside the heap and must wrap.
// One request is in work at a time.
// After reset a clearing pass over the HEAP_BYTES/4 words and the initial
// layout run before req_tready rises. A result waits in rsp while the next
// request is taken.
module boundary_tag_heap_allocator_core
   import hba_pkg::*;
#(
   parameter int HEAP_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // request_size, block_address
   input  logic                   req_tuser,  // operation
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // address, status, zero fill
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   logic [CFG_W-1:0] chunk_ff, chunk_in;
   logic [CFG_W-1:0] limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hba_res_type      rsp_ff, rsp_in;

   logic             seq_idle;
   logic             res_valid, res_ready;
   hba_res_type      res;
   hba_cmd_type      cmd;

   assign cmd.op   = req_tuser;
   assign cmd.size = req_tdata[15:0];
   assign cmd.addr = req_tdata[31:16];

   hba_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd       (cmd),
      .idle      (seq_idle),
      .chunk     (chunk_ff),
      .limit     (limit_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign req_tready = seq_idle;
   assign csr_ready  = 1'b1;
   assign res_ready  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      chunk_in     = chunk_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHUNK: chunk_in = csr_data;
            CSR_LIMIT: limit_in = csr_data;
            default:   ;
         endcase
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= CHUNK_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ff.status, rsp_ff.addr};

endmodule

// File: hdl/hba_wrap.sv
// Word index wrap unit: reduces a word number modulo the heap word count.
// In-range numbers pass in the same cycle; others go through a reciprocal
// multiply, whose quotient is registered, and one correcting subtract.
module hba_wrap
   import hba_pkg::*;
#(
   parameter int WORDS = 16384
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [POS_W-3:0]         word,
   output logic                     done,
   output logic [$clog2(WORDS)-1:0] index
);

   localparam int IW = $clog2(WORDS);
   localparam int WW = POS_W - 2;
   localparam int QW = WW + 1 - IW;
   localparam logic [31:0] RECIP = 32'((64'd1 << (WW + IW)) / 64'(WORDS));

   logic            busy_ff, busy_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [2*WW:0]   prod;
   logic [WW-1:0]   diff;
   logic [IW:0]     part;
   logic [IW:0]     reduced;
   logic            fast;

   assign fast    = word < WW'(WORDS);
   assign prod    = (2*WW+1)'(word) * (2*WW+1)'(RECIP);
   assign diff    = word - WW'(quot_ff) * WW'(WORDS);
   assign part    = diff[IW:0];
   assign reduced = (part >= (IW+1)'(WORDS)) ? part - (IW+1)'(WORDS) : part;

   always_comb begin
      busy_in = 1'b0;
      quot_in = quot_ff;
      done    = 1'b0;
      index   = word[IW-1:0];
      if (busy_ff) begin
         done  = 1'b1;
         index = reduced[IW-1:0];
      end else if (start) begin
         if (fast) begin
            done = 1'b1;
         end else begin
            busy_in = 1'b1;
            quot_in = prod[2*WW:WW+IW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quot_ff <= quot_in;
   end

endmodule

// File: hdl/hba_heap_mem.sv
// Heap word memory: one port, synchronous write, registered read data.
// Depends on hba_pkg for the word width.
module hba_heap_mem
   import hba_pkg::*;
#(
   parameter int WORDS = 16384
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(WORDS)-1:0] idx,
   input  logic [POS_W-1:0]         wdata,
   output logic [POS_W-1:0]         rdata
);

   logic [POS_W-1:0] mem_ff [WORDS];
   logic [POS_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[idx] <= wdata;
         end else begin
            rdata_ff <= mem_ff[idx];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/hba_seq.sv
// Allocator sequencer: clear pass, initial layout, first-fit walk, growth,
// split and coalesce, all as read/modify/write steps on hba_heap_mem.
// Depends on hba_pkg, hba_wrap and hba_heap_mem.
module hba_seq
   import hba_pkg::*;
#(
   parameter int HEAP_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  hba_cmd_type       cmd,
   output logic              idle,
   input  logic [CFG_W-1:0]  chunk,
   input  logic [CFG_W-1:0]  limit,
   output logic              res_valid,
   input  logic              res_ready,
   output hba_res_type       res
);

   localparam int WORDS  = HEAP_BYTES / 4;
   localparam int IW     = $clog2(WORDS);
   localparam int ROOM   = ((HEAP_BYTES - 16) / 8) * 8;
   localparam int FIRST  = (START_CHUNK > ROOM) ? ROOM : START_CHUNK;
   localparam int LIM_W  = 21;
   localparam int GS_W   = 18;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_REL   = 2'd2;

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_I0   = 5'd1;
   localparam logic [4:0] S_I1   = 5'd2;
   localparam logic [4:0] S_I2   = 5'd3;
   localparam logic [4:0] S_I3   = 5'd4;
   localparam logic [4:0] S_IDLE = 5'd5;
   localparam logic [4:0] S_ACC  = 5'd6;
   localparam logic [4:0] S_DONE = 5'd7;
   localparam logic [4:0] S_F0   = 5'd8;
   localparam logic [4:0] S_F1   = 5'd9;
   localparam logic [4:0] S_N0   = 5'd10;
   localparam logic [4:0] S_G0   = 5'd11;
   localparam logic [4:0] S_G1   = 5'd12;
   localparam logic [4:0] S_G2   = 5'd13;
   localparam logic [4:0] S_M0   = 5'd14;
   localparam logic [4:0] S_M1   = 5'd15;
   localparam logic [4:0] S_M2   = 5'd16;
   localparam logic [4:0] S_M3   = 5'd17;
   localparam logic [4:0] S_M4   = 5'd18;
   localparam logic [4:0] S_MEND = 5'd19;
   localparam logic [4:0] S_T0   = 5'd20;
   localparam logic [4:0] S_T1   = 5'd21;
   localparam logic [4:0] S_T2   = 5'd22;
   localparam logic [4:0] S_T3   = 5'd23;
   localparam logic [4:0] S_T4   = 5'd24;
   localparam logic [4:0] S_T5   = 5'd25;
   localparam logic [4:0] S_R1   = 5'd26;
   localparam logic [4:0] S_R2   = 5'd27;

   logic [4:0]       state_ff, state_in;
   logic [4:0]       ret_ff, ret_in;
   logic [1:0]       mode_ff, mode_in;
   logic [IW-1:0]    clr_ff, clr_in;
   logic [POS_W-1:0] acc_pos_ff, acc_pos_in;
   logic             acc_we_ff, acc_we_in;
   logic [POS_W-1:0] acc_data_ff, acc_data_in;
   logic [POS_W-1:0] bp_ff, bp_in;
   logic [POS_W:0]   walk_ff, walk_in;
   logic [POS_W-1:0] size_ff, size_in;
   logic [POS_W-1:0] psz_ff, psz_in;
   logic             pu_ff, pu_in;
   logic [CFG_W-1:0] need_ff, need_in;
   logic [GS_W-1:0]  gsize_ff, gsize_in;
   logic [CFG_W-1:0] brk_ff, brk_in;
   hba_res_type      res_ff, res_in;

   logic             mem_en, mem_we;
   logic [IW-1:0]    mem_idx;
   logic [POS_W-1:0] mem_rdata;
   logic             wrap_start, wrap_done;
   logic [IW-1:0]    wrap_idx;

   logic [POS_W-1:0] rd_size;
   logic [POS_W-1:0] rem;
   logic [POS_W-1:0] nsize;
   logic [CFG_W-1:0] ext;
   logic [GS_W-1:0]  gsize_calc;
   logic [LIM_W-1:0] eff_limit;
   logic [LIM_W-1:0] grown;
   logic [CFG_W:0]   need_calc;

   assign rd_size    = {mem_rdata[POS_W-1:3], 3'b000};
   assign rem        = rd_size - POS_W'(need_ff);
   assign nsize      = size_ff + (pu_ff ? '0 : psz_ff) + (mem_rdata[0] ? '0 : rd_size);
   assign ext        = (need_ff > chunk) ? need_ff : chunk;
   assign gsize_calc = (GS_W'(ext[CFG_W-1:2]) + GS_W'(ext[2])) << 2;
   assign eff_limit  = (LIM_W'(limit) > LIM_W'(HEAP_BYTES)) ? LIM_W'(HEAP_BYTES)
                                                             : LIM_W'(limit);
   assign grown      = LIM_W'(brk_ff) + LIM_W'(gsize_calc);
   assign need_calc  = ({1'b0, cmd.size} + (CFG_W+1)'(15)) & ~(CFG_W+1)'(7);

   hba_wrap #(.WORDS(WORDS)) u_wrap (
      .clock (clock),
      .reset (reset),
      .start (wrap_start),
      .word  (acc_pos_ff[POS_W-1:2]),
      .done  (wrap_done),
      .index (wrap_idx)
   );

   hba_heap_mem #(.WORDS(WORDS)) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .idx   (mem_idx),
      .wdata (acc_data_ff),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      mode_in     = mode_ff;
      clr_in      = clr_ff;
      acc_pos_in  = acc_pos_ff;
      acc_we_in   = acc_we_ff;
      acc_data_in = acc_data_ff;
      bp_in       = bp_ff;
      walk_in     = walk_ff;
      size_in     = size_ff;
      psz_in      = psz_ff;
      pu_in       = pu_ff;
      need_in     = need_ff;
      gsize_in    = gsize_ff;
      brk_in      = brk_ff;
      res_in      = res_ff;
      mem_en      = 1'b0;
      mem_we      = 1'b0;
      mem_idx     = wrap_idx;
      wrap_start  = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            mem_idx     = clr_ff;
            acc_data_in = '0;
            clr_in      = clr_ff + IW'(1);
            if (clr_ff == IW'(WORDS - 1)) begin
               state_in = S_I0;
            end
         end
         S_I0: begin
            acc_pos_in = 32'd4; acc_we_in = 1'b1; acc_data_in = 32'd9;
            ret_in = S_I1; state_in = S_ACC;
         end
         S_I1: begin
            acc_pos_in = 32'd8; acc_we_in = 1'b1; acc_data_in = 32'd9;
            ret_in = S_I2; state_in = S_ACC;
         end
         S_I2: begin
            acc_pos_in = 32'd12; acc_we_in = 1'b1; acc_data_in = 32'd1;
            ret_in = S_I3; state_in = S_ACC;
         end
         S_I3: begin
            brk_in   = CFG_W'(16);
            gsize_in = GS_W'(FIRST);
            mode_in  = MODE_INIT;
            state_in = S_G0;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               res_in.addr   = '0;
               res_in.status = ST_DONE;
               if (cmd.op == OP_ALLOC) begin
                  if (cmd.size == '0) begin
                     res_in.status = ST_ZERO;
                     state_in      = S_DONE;
                  end else begin
                     need_in  = (cmd.size <= SIZE_W'(8)) ? CFG_W'(16) : need_calc[CFG_W-1:0];
                     walk_in  = (POS_W+1)'(8);
                     state_in = S_F0;
                  end
               end else begin
                  bp_in = POS_W'(cmd.addr);
                  if (cmd.addr[2:0] == 3'b000 && cmd.addr >= SIZE_W'(16) &&
                      CFG_W'(cmd.addr) < brk_ff) begin
                     acc_pos_in = POS_W'(cmd.addr) - 32'd4; acc_we_in = 1'b0;
                     ret_in = S_R1; state_in = S_ACC;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_ACC: begin
            wrap_start = 1'b1;
            if (wrap_done) begin
               mem_en   = 1'b1;
               mem_we   = acc_we_ff;
               state_in = ret_ff;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         S_F0: begin
            if (walk_ff >= (POS_W+1)'(brk_ff)) begin
               state_in = S_N0;
            end else begin
               acc_pos_in = walk_ff[POS_W-1:0] - 32'd4; acc_we_in = 1'b0;
               ret_in = S_F1; state_in = S_ACC;
            end
         end
         S_F1: begin
            if (rd_size == '0) begin
               state_in = S_N0;
            end else if (!mem_rdata[0] && POS_W'(need_ff) <= rd_size) begin
               bp_in    = walk_ff[POS_W-1:0];
               state_in = S_T0;
            end else begin
               walk_in  = walk_ff + (POS_W+1)'(rd_size);
               state_in = S_F0;
            end
         end
         S_N0: begin
            if (grown > eff_limit) begin
               res_in.status = ST_OOM;
               state_in      = S_DONE;
            end else begin
               gsize_in = gsize_calc;
               mode_in  = MODE_ALLOC;
               state_in = S_G0;
            end
         end
         S_G0: begin
            bp_in      = POS_W'(brk_ff);
            acc_pos_in = POS_W'(brk_ff) - 32'd4; acc_we_in = 1'b1;
            acc_data_in = POS_W'(gsize_ff);
            ret_in = S_G1; state_in = S_ACC;
         end
         S_G1: begin
            acc_pos_in = bp_ff + POS_W'(gsize_ff) - 32'd8; acc_we_in = 1'b1;
            acc_data_in = POS_W'(gsize_ff);
            ret_in = S_G2; state_in = S_ACC;
         end
         S_G2: begin
            brk_in     = brk_ff + CFG_W'(gsize_ff);
            acc_pos_in = bp_ff + POS_W'(gsize_ff) - 32'd4; acc_we_in = 1'b1;
            acc_data_in = 32'd1;
            ret_in = S_M0; state_in = S_ACC;
         end
         S_M0: begin
            acc_pos_in = bp_ff - 32'd4; acc_we_in = 1'b0;
            ret_in = S_M1; state_in = S_ACC;
         end
         S_M1: begin
            size_in    = rd_size;
            acc_pos_in = bp_ff - 32'd8; acc_we_in = 1'b0;
            ret_in = S_M2; state_in = S_ACC;
         end
         S_M2: begin
            pu_in      = mem_rdata[0];
            psz_in     = rd_size;
            acc_pos_in = bp_ff + size_ff - 32'd4; acc_we_in = 1'b0;
            ret_in = S_M3; state_in = S_ACC;
         end
         S_M3: begin
            if (pu_ff && mem_rdata[0]) begin
               state_in = S_MEND;
            end else begin
               size_in     = nsize;
               bp_in       = bp_ff - (pu_ff ? '0 : psz_ff);
               acc_pos_in  = bp_ff - (pu_ff ? '0 : psz_ff) - 32'd4; acc_we_in = 1'b1;
               acc_data_in = nsize;
               ret_in = S_M4; state_in = S_ACC;
            end
         end
         S_M4: begin
            acc_pos_in = bp_ff + size_ff - 32'd8; acc_we_in = 1'b1;
            acc_data_in = size_ff;
            ret_in = S_MEND; state_in = S_ACC;
         end
         S_MEND: begin
            case (mode_ff)
               MODE_INIT:  state_in = S_IDLE;
               MODE_ALLOC: state_in = S_T0;
               default:    state_in = S_DONE;
            endcase
         end
         S_T0: begin
            res_in.addr = bp_ff[SIZE_W-1:0];
            acc_pos_in  = bp_ff - 32'd4; acc_we_in = 1'b0;
            ret_in = S_T1; state_in = S_ACC;
         end
         S_T1: begin
            size_in   = rd_size;
            acc_we_in = 1'b1;
            acc_pos_in = bp_ff - 32'd4;
            state_in  = S_ACC;
            if (rem >= 32'd16) begin
               acc_data_in = POS_W'(need_ff) | 32'd1;
               ret_in      = S_T2;
            end else begin
               acc_data_in = rd_size | 32'd1;
               ret_in      = S_T5;
            end
         end
         S_T2: begin
            acc_pos_in = bp_ff + POS_W'(need_ff) - 32'd8; acc_we_in = 1'b1;
            acc_data_in = POS_W'(need_ff) | 32'd1;
            ret_in = S_T3; state_in = S_ACC;
         end
         S_T3: begin
            acc_pos_in = bp_ff + POS_W'(need_ff) - 32'd4; acc_we_in = 1'b1;
            acc_data_in = size_ff - POS_W'(need_ff);
            ret_in = S_T4; state_in = S_ACC;
         end
         S_T4: begin
            acc_pos_in = bp_ff + size_ff - 32'd8; acc_we_in = 1'b1;
            acc_data_in = size_ff - POS_W'(need_ff);
            ret_in = S_DONE; state_in = S_ACC;
         end
         S_T5: begin
            acc_pos_in = bp_ff + size_ff - 32'd8; acc_we_in = 1'b1;
            acc_data_in = size_ff | 32'd1;
            ret_in = S_DONE; state_in = S_ACC;
         end
         S_R1: begin
            if (mem_rdata[0]) begin
               size_in     = rd_size;
               mode_in     = MODE_REL;
               acc_pos_in  = bp_ff - 32'd4; acc_we_in = 1'b1;
               acc_data_in = rd_size;
               ret_in = S_R2; state_in = S_ACC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_R2: begin
            acc_pos_in = bp_ff + size_ff - 32'd8; acc_we_in = 1'b1;
            acc_data_in = size_ff;
            ret_in = S_M0; state_in = S_ACC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         mode_ff     <= MODE_INIT;
         ret_ff      <= S_IDLE;
         acc_data_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         mode_ff     <= mode_in;
         ret_ff      <= ret_in;
         acc_data_ff <= acc_data_in;
      end
      acc_pos_ff  <= acc_pos_in;
      acc_we_ff   <= acc_we_in;
      bp_ff       <= bp_in;
      walk_ff     <= walk_in;
      size_ff     <= size_in;
      psz_ff      <= psz_in;
      pu_ff       <= pu_in;
      need_ff     <= need_in;
      gsize_ff    <= gsize_in;
      brk_ff      <= brk_in;
      res_ff      <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

// File: hdl/hba_checker.sv
// Port-level checks for boundary_tag_heap_allocator_core, bound to the top.
// Depends on hba_pkg.
module hba_checker
   import hba_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [31:0]            req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [23:0]            rsp_tdata,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CFG_W-1:0]       csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3)
      else $error("undefined status code");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != ST_DONE |-> rsp_tdata[15:0] == 16'd0)
      else $error("failed request reports an address");

   a_addr_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] == 3'b000 && rsp_tdata[23:18] == 6'd0)
      else $error("misaligned address or nonzero fill");

endmodule

bind boundary_tag_heap_allocator_core hba_checker u_hba_checker (.*);
